### sv/lsct_pkg.sv
// ----------------------------------------------------------------------------
// lsct_pkg
// Shared constants and types of the sector cache tag and replacement engine.
// ----------------------------------------------------------------------------
package lsct_pkg;

   localparam int WAYS    = 64;
   localparam int WAY_W   = $clog2(WAYS);
   localparam int TAG_W   = 32;
   localparam int STAMP_W = 64;
   localparam int MODE_W  = 2;
   localparam int OUT_WAY_W = 6;

   localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESOLVE
   } state_type;

endpackage

### sv/lru_sector_cache_tags.sv
// ----------------------------------------------------------------------------
// lru_sector_cache_tags
// Tag lookup and least-recently-used replacement for a fully associative
// write-back sector cache; one shared tag/stamp compare walks all ways.
// ----------------------------------------------------------------------------
// Usage:
//   An item (req_mode, req_sector) is taken at a rising edge with start high
//   and busy low. Read and write items give one result; a flush item gives
//   one result per dirty way in ascending way order, or none when nothing is
//   dirty; mode 3 is dropped without effect.
//   Each result is on the rsp_ ports for one cycle, marked by rsp_strobe, and
//   rsp_last flags the final result of an item. The receiver cannot stall.
// Timing:
//   The tag and stamp memories are read one way per cycle through a single
//   compare unit, so the walk over the ways sets the latency. A read or write
//   is busy through the scan, drain and resolve states; its result shows in
//   the cycle busy drops. A flush is busy through the scan and drain states;
//   its results stream out during the walk, the last one no later than the
//   cycle busy drops. Mode 3 never sets busy; a new item may start once idle.
// Reset:
//   Synchronous reset clears valid and dirty marks and the access counter.
//   Tag and stamp memories need no clearing: a way's entries are used only
//   after it has been filled.
// ----------------------------------------------------------------------------
module lru_sector_cache_tags
   import lsct_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [TAG_W-1:0]     req_sector,
   output logic                 rsp_strobe,
   output logic [OUT_WAY_W-1:0] rsp_way,
   output logic                 rsp_hit,
   output logic                 rsp_fill,
   output logic                 rsp_writeback,
   output logic [TAG_W-1:0]     rsp_writeback_sector,
   output logic                 rsp_last
);

   localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

   state_type state_ff, state_in;

   logic [MODE_W-1:0]  mode_ff;
   logic [TAG_W-1:0]   sector_ff;
   logic               accept;

   logic [WAY_W-1:0]   addr_ff, addr_in;
   logic               pipe_vld_ff, pipe_vld_in;
   logic [WAY_W-1:0]   pipe_idx_ff;
   logic [TAG_W-1:0]   tag_rd_ff;
   logic [STAMP_W-1:0] age_rd_ff;

   logic               found_ff, found_in;
   logic [WAY_W-1:0]   match_idx_ff, match_idx_in;
   logic               inv_found_ff, inv_found_in;
   logic [WAY_W-1:0]   inv_idx_ff, inv_idx_in;
   logic [WAY_W-1:0]   min_idx_ff, min_idx_in;
   logic [STAMP_W-1:0] min_age_ff, min_age_in;
   logic [TAG_W-1:0]   min_tag_ff, min_tag_in;

   logic [WAYS-1:0]    valid_ff, valid_in;
   logic [WAYS-1:0]    dirty_ff, dirty_in;
   logic [STAMP_W-1:0] counter_ff, counter_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [OUT_WAY_W-1:0] rsp_way_ff, rsp_way_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 rsp_fill_ff, rsp_fill_in;
   logic                 rsp_wb_ff, rsp_wb_in;
   logic [TAG_W-1:0]     rsp_wbs_ff, rsp_wbs_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic               tag_we, age_we;
   logic [WAY_W-1:0]   mem_waddr;
   logic [STAMP_W-1:0] age_wdata;

   logic [TAG_W-1:0]   tag_mem [WAYS];
   logic [STAMP_W-1:0] age_mem [WAYS];

   logic               is_write;
   logic               is_access;
   logic [WAYS-1:0]    idx_onehot;
   logic [WAY_W-1:0]   slot;

   assign accept    = start && !busy;
   assign is_write  = (mode_ff == MODE_WRITE);
   assign is_access = (req_mode == MODE_READ) || (req_mode == MODE_WRITE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (is_access || req_mode == MODE_FLUSH)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (addr_ff == LAST_WAY) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mode_ff == MODE_FLUSH) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      busy         = (state_ff != ST_IDLE);
      addr_in      = addr_ff;
      pipe_vld_in  = (state_ff == ST_SCAN);
      found_in     = found_ff;
      match_idx_in = match_idx_ff;
      inv_found_in = inv_found_ff;
      inv_idx_in   = inv_idx_ff;
      min_idx_in   = min_idx_ff;
      min_age_in   = min_age_ff;
      min_tag_in   = min_tag_ff;
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      counter_in   = counter_ff;
      tag_we       = 1'b0;
      age_we       = 1'b0;
      mem_waddr    = '0;
      age_wdata    = counter_ff + STAMP_W'(1);
      slot         = '0;
      idx_onehot   = WAYS'(1) << pipe_idx_ff;

      rsp_strobe_in = 1'b0;
      rsp_way_in    = rsp_way_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_wb_in     = rsp_wb_ff;
      rsp_wbs_in    = rsp_wbs_ff;
      rsp_last_in   = rsp_last_ff;

      if (state_ff == ST_IDLE && accept) begin
         addr_in      = '0;
         found_in     = 1'b0;
         inv_found_in = 1'b0;
      end
      if (state_ff == ST_SCAN) begin
         addr_in = addr_ff + WAY_W'(1);
      end

      // compare stage, one way per cycle
      if (pipe_vld_ff) begin
         if (mode_ff == MODE_FLUSH) begin
            if (valid_ff[pipe_idx_ff] && dirty_ff[pipe_idx_ff]) begin
               dirty_in[pipe_idx_ff] = 1'b0;
               rsp_strobe_in = 1'b1;
               rsp_way_in    = OUT_WAY_W'(pipe_idx_ff);
               rsp_hit_in    = 1'b0;
               rsp_fill_in   = 1'b0;
               rsp_wb_in     = 1'b1;
               rsp_wbs_in    = tag_rd_ff;
               // ascending walk: last when no dirty way remains above this one
               rsp_last_in   = ((valid_ff & dirty_ff & ~idx_onehot) == '0);
            end
         end else begin
            if (!found_ff && valid_ff[pipe_idx_ff] && tag_rd_ff == sector_ff) begin
               found_in     = 1'b1;
               match_idx_in = pipe_idx_ff;
            end
            if (!inv_found_ff && !valid_ff[pipe_idx_ff]) begin
               inv_found_in = 1'b1;
               inv_idx_in   = pipe_idx_ff;
            end
            if (pipe_idx_ff == '0 || age_rd_ff < min_age_ff) begin
               min_idx_in = pipe_idx_ff;
               min_age_in = age_rd_ff;
               min_tag_in = tag_rd_ff;
            end
         end
      end

      if (state_ff == ST_RESOLVE) begin
         counter_in    = counter_ff + STAMP_W'(1);
         rsp_strobe_in = 1'b1;
         rsp_last_in   = 1'b1;
         rsp_wb_in     = 1'b0;
         rsp_wbs_in    = '0;
         if (found_ff) begin
            slot           = match_idx_ff;
            rsp_hit_in     = 1'b1;
            rsp_fill_in    = 1'b0;
            dirty_in[slot] = dirty_ff[slot] | is_write;
         end else begin
            // lowest invalid way first, else the oldest stamp
            slot           = inv_found_ff ? inv_idx_ff : min_idx_ff;
            rsp_hit_in     = 1'b0;
            rsp_fill_in    = 1'b1;
            if (!inv_found_ff && dirty_ff[min_idx_ff]) begin
               rsp_wb_in  = 1'b1;
               rsp_wbs_in = min_tag_ff;
            end
            valid_in[slot] = 1'b1;
            dirty_in[slot] = is_write;
            tag_we         = 1'b1;
         end
         rsp_way_in = OUT_WAY_W'(slot);
         age_we     = 1'b1;
         mem_waddr  = slot;
         age_wdata  = counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pipe_vld_ff   <= 1'b0;
         valid_ff      <= '0;
         dirty_ff      <= '0;
         counter_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
         found_ff      <= 1'b0;
         inv_found_ff  <= 1'b0;
         addr_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         pipe_vld_ff   <= pipe_vld_in;
         valid_ff      <= valid_in;
         dirty_ff      <= dirty_in;
         counter_ff    <= counter_in;
         rsp_strobe_ff <= rsp_strobe_in;
         found_ff      <= found_in;
         inv_found_ff  <= inv_found_in;
         addr_ff       <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_mode;
         sector_ff <= req_sector;
      end
      pipe_idx_ff  <= addr_ff;
      match_idx_ff <= match_idx_in;
      inv_idx_ff   <= inv_idx_in;
      min_idx_ff   <= min_idx_in;
      min_age_ff   <= min_age_in;
      min_tag_ff   <= min_tag_in;
      rsp_way_ff   <= rsp_way_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_wb_ff    <= rsp_wb_in;
      rsp_wbs_ff   <= rsp_wbs_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // tag and stamp memories, registered read
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[mem_waddr] <= sector_ff;
      end
      if (age_we) begin
         age_mem[mem_waddr] <= age_wdata;
      end
      tag_rd_ff <= tag_mem[addr_ff];
      age_rd_ff <= age_mem[addr_ff];
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_way              = rsp_way_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_fill             = rsp_fill_ff;
   assign rsp_writeback        = rsp_wb_ff;
   assign rsp_writeback_sector = rsp_wbs_ff;
   assign rsp_last             = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_hit_no_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_hit |-> !rsp_fill && !rsp_writeback)
      else $error("hit result carries fill or write-back");

   a_access_busy: assert property (@(posedge clock) disable iff (reset)
      accept && is_access |=> busy)
      else $error("access item taken but block not busy");

   a_resolve_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESOLVE |=> rsp_strobe && rsp_last)
      else $error("access item ended without its result");

   a_more_results_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
      else $error("non-final flush result while idle");
`endif

endmodule
